// ===== hw/rtl/pfl_pkg.sv =====
// shared types and constants for the proportional follower with lead
package pfl_pkg;

    localparam int unsigned AddrWidth = 4;
    localparam logic [23:0] GainReset = 24'd65536;
    localparam logic [16:0] RateReset = 17'd65536;
    localparam logic [15:0] InvMaxSpeedReset = 16'd6554;
    localparam logic [16:0] OneQ16 = 17'd65536;
    localparam int unsigned SqrtSteps = 32;
    localparam int unsigned DivSteps = 17;

    typedef enum logic [1:0] {
        REG_GAIN = 2'd0,
        REG_RATE = 2'd1,
        REG_INV_MAX_SPEED = 2'd2,
        REG_NONE = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] current_pos_x;
        logic signed [31:0] current_pos_y;
        logic signed [31:0] current_pos_z;
        logic signed [31:0] goal_pos_x;
        logic signed [31:0] goal_pos_y;
        logic signed [31:0] goal_pos_z;
        logic signed [31:0] target_vel_x;
        logic signed [31:0] target_vel_y;
        logic signed [31:0] target_vel_z;
        logic [15:0]        frame_time;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
    } out_item_t;

    typedef struct packed {
        logic [23:0] position_gain;
        logic [16:0] lead_rate;
        logic [15:0] inverse_max_speed;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQX, ST_SQZ, ST_ADDSQ, ST_SQRT, ST_FRACM, ST_FRACS,
        ST_NUM, ST_DIV, ST_DIRST, ST_TM, ST_TS, ST_OFFM, ST_OFFU,
        ST_VELM, ST_VELU, ST_POSM, ST_POSU, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_SQX, OP_SQZ, OP_ADDSQ, OP_SQRT, OP_FRACM, OP_FRACS,
        OP_NUM, OP_DIV, OP_DIRST, OP_TM, OP_TS, OP_OFFM, OP_OFFU,
        OP_VELM, OP_VELU, OP_POSM, OP_POSU, OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
    } cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        hi = 68'sd2147483647;
        lo = -68'sd2147483648;
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== hw/rtl/pfl_ctrl.sv =====
// sequencer for one item: square root, divisions, lead update and control
module pfl_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output pfl_pkg::cmd_t cmd
);

    pfl_pkg::state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] ax_reg, ax_next;
    logic       mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= pfl_pkg::ST_IDLE;
            cnt_reg    <= 5'd0;
            ax_reg     <= 2'd0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ax_reg     <= ax_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_ready = (state_reg == pfl_pkg::ST_IDLE);
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ax_next     = ax_reg;
        mvalid_next = mvalid_reg && !m_ready;
        cmd.op      = pfl_pkg::OP_NOP;
        cmd.axis    = ax_reg;
        unique case (state_reg)
            pfl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = pfl_pkg::OP_LOAD;
                    state_next = pfl_pkg::ST_SQX;
                end
            end
            pfl_pkg::ST_SQX: begin
                cmd.op     = pfl_pkg::OP_SQX;
                state_next = pfl_pkg::ST_SQZ;
            end
            pfl_pkg::ST_SQZ: begin
                cmd.op     = pfl_pkg::OP_SQZ;
                state_next = pfl_pkg::ST_ADDSQ;
            end
            pfl_pkg::ST_ADDSQ: begin
                cmd.op     = pfl_pkg::OP_ADDSQ;
                state_next = pfl_pkg::ST_SQRT;
            end
            pfl_pkg::ST_SQRT: begin
                cmd.op = pfl_pkg::OP_SQRT;
                if (cnt_reg == 5'(pfl_pkg::SqrtSteps - 1)) begin
                    cnt_next   = 5'd0;
                    state_next = pfl_pkg::ST_FRACM;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            pfl_pkg::ST_FRACM: begin
                cmd.op     = pfl_pkg::OP_FRACM;
                state_next = pfl_pkg::ST_FRACS;
            end
            pfl_pkg::ST_FRACS: begin
                cmd.op     = pfl_pkg::OP_FRACS;
                state_next = pfl_pkg::ST_NUM;
            end
            pfl_pkg::ST_NUM: begin
                cmd.op     = pfl_pkg::OP_NUM;
                state_next = pfl_pkg::ST_DIV;
            end
            pfl_pkg::ST_DIV: begin
                cmd.op = pfl_pkg::OP_DIV;
                if (cnt_reg == 5'(pfl_pkg::DivSteps - 1)) begin
                    cnt_next   = 5'd0;
                    state_next = pfl_pkg::ST_DIRST;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            pfl_pkg::ST_DIRST: begin
                cmd.op = pfl_pkg::OP_DIRST;
                if (ax_reg == 2'd0) begin
                    ax_next    = 2'd1;
                    state_next = pfl_pkg::ST_NUM;
                end else begin
                    ax_next    = 2'd0;
                    state_next = pfl_pkg::ST_TM;
                end
            end
            pfl_pkg::ST_TM: begin
                cmd.op     = pfl_pkg::OP_TM;
                state_next = pfl_pkg::ST_TS;
            end
            pfl_pkg::ST_TS: begin
                cmd.op     = pfl_pkg::OP_TS;
                state_next = pfl_pkg::ST_OFFM;
            end
            pfl_pkg::ST_OFFM: begin
                cmd.op     = pfl_pkg::OP_OFFM;
                state_next = pfl_pkg::ST_OFFU;
            end
            pfl_pkg::ST_OFFU: begin
                cmd.op = pfl_pkg::OP_OFFU;
                if (ax_reg == 2'd0) begin
                    ax_next    = 2'd1;
                    state_next = pfl_pkg::ST_OFFM;
                end else begin
                    ax_next    = 2'd0;
                    state_next = pfl_pkg::ST_VELM;
                end
            end
            pfl_pkg::ST_VELM: begin
                cmd.op     = pfl_pkg::OP_VELM;
                state_next = pfl_pkg::ST_VELU;
            end
            pfl_pkg::ST_VELU: begin
                cmd.op     = pfl_pkg::OP_VELU;
                state_next = pfl_pkg::ST_POSM;
            end
            pfl_pkg::ST_POSM: begin
                cmd.op     = pfl_pkg::OP_POSM;
                state_next = pfl_pkg::ST_POSU;
            end
            pfl_pkg::ST_POSU: begin
                cmd.op = pfl_pkg::OP_POSU;
                if (ax_reg == 2'd2) begin
                    ax_next    = 2'd0;
                    state_next = pfl_pkg::ST_DONE;
                end else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = pfl_pkg::ST_VELM;
                end
            end
            pfl_pkg::ST_DONE: begin
                if (!mvalid_reg || m_ready) begin
                    cmd.op      = pfl_pkg::OP_OUT;
                    mvalid_next = 1'b1;
                    state_next  = pfl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfl_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == pfl_pkg::ST_SQX)
        else $error("accepted item did not start the sequence");
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 5'd0 |-> state_reg == pfl_pkg::ST_SQRT || state_reg == pfl_pkg::ST_DIV)
        else $error("step counter running outside an iterative phase");
    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pfl_pkg::ST_DONE && (!mvalid_reg || m_ready) |=> m_valid)
        else $error("finished item not presented");
`endif

endmodule

// ===== hw/rtl/pfl_datapath.sv =====
// shared multiplier, square root, divider and state registers
module pfl_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  pfl_pkg::cmd_t       cmd,
    input  pfl_pkg::cfg_t       cfg,
    input  pfl_pkg::in_item_t   in_data,
    output pfl_pkg::out_item_t  out_data
);

    pfl_pkg::in_item_t  in_reg;
    pfl_pkg::out_item_t out_reg;
    logic signed [66:0] p_reg;
    logic [63:0]        rad_reg;
    logic [63:0]        r_reg;
    logic [63:0]        bit_reg;
    logic [16:0]        frac_reg;
    logic [47:0]        d_reg;
    logic [16:0]        q_reg;
    logic [16:0]        t_reg;
    logic signed [17:0] dir_reg [2];
    logic signed [31:0] off_reg [2];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] pos_reg [3];

    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [66:0] prod;
    logic signed [31:0] cur_s [3];
    logic signed [31:0] goal_s [3];
    logic signed [31:0] tv_s [3];
    logic signed [31:0] lead_s [3];
    logic signed [32:0] tvx_e, tvz_e;
    logic [32:0]        mag_x, mag_z, mag_sel;
    logic [16:0]        rate_c;
    logic [63:0]        sq_try;
    logic signed [67:0] p_shift;
    logic               neg_sel;
    logic [1:0]         ax;

    assign ax = cmd.axis;
    assign cur_s[0]  = in_reg.current_pos_x;
    assign cur_s[1]  = in_reg.current_pos_y;
    assign cur_s[2]  = in_reg.current_pos_z;
    assign goal_s[0] = in_reg.goal_pos_x;
    assign goal_s[1] = in_reg.goal_pos_y;
    assign goal_s[2] = in_reg.goal_pos_z;
    assign tv_s[0]   = in_reg.target_vel_x;
    assign tv_s[1]   = in_reg.target_vel_y;
    assign tv_s[2]   = in_reg.target_vel_z;
    assign lead_s[0] = off_reg[0];
    assign lead_s[1] = 32'sd0;
    assign lead_s[2] = off_reg[1];

    assign tvx_e   = {in_reg.target_vel_x[31], in_reg.target_vel_x};
    assign tvz_e   = {in_reg.target_vel_z[31], in_reg.target_vel_z};
    assign mag_x   = tvx_e[32] ? 33'(-tvx_e) : 33'(tvx_e);
    assign mag_z   = tvz_e[32] ? 33'(-tvz_e) : 33'(tvz_e);
    assign mag_sel = ax[0] ? mag_z : mag_x;
    assign neg_sel = ax[0] ? in_reg.target_vel_z[31] : in_reg.target_vel_x[31];
    assign rate_c  = (cfg.lead_rate > pfl_pkg::OneQ16) ? pfl_pkg::OneQ16 : cfg.lead_rate;
    assign sq_try  = r_reg + bit_reg;
    assign p_shift = $signed({{17{p_reg[66]}}, p_reg[66:16]});
    assign prod    = mul_a * mul_b;
    assign out_data = out_reg;

    always_comb begin
        mul_a = 34'sd0;
        mul_b = 33'sd0;
        unique case (cmd.op)
            pfl_pkg::OP_SQX: begin
                mul_a = $signed({1'b0, mag_x});
                mul_b = $signed(mag_x);
            end
            pfl_pkg::OP_SQZ: begin
                mul_a = $signed({1'b0, mag_z});
                mul_b = $signed(mag_z);
            end
            pfl_pkg::OP_FRACM: begin
                mul_a = $signed({2'b0, r_reg[31:0]});
                mul_b = $signed({17'b0, cfg.inverse_max_speed});
            end
            pfl_pkg::OP_NUM: begin
                mul_a = $signed({1'b0, mag_sel});
                mul_b = $signed({16'b0, frac_reg});
            end
            pfl_pkg::OP_TM: begin
                mul_a = $signed({17'b0, rate_c});
                mul_b = $signed({17'b0, in_reg.frame_time});
            end
            pfl_pkg::OP_OFFM: begin
                mul_a = 34'(dir_reg[ax[0]]) - 34'(off_reg[ax[0]]);
                mul_b = $signed({16'b0, t_reg});
            end
            pfl_pkg::OP_VELM: begin
                mul_a = 34'(goal_s[ax]) + 34'(lead_s[ax]) - 34'(cur_s[ax]);
                mul_b = $signed({9'b0, cfg.position_gain});
            end
            pfl_pkg::OP_POSM: begin
                mul_a = 34'(vel_reg[ax]);
                mul_b = $signed({17'b0, in_reg.frame_time});
            end
            default: begin
                mul_a = 34'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    // lead offsets are state and reset to zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg[0] <= 32'sd0;
            off_reg[1] <= 32'sd0;
        end else if (cmd.op == pfl_pkg::OP_OFFU) begin
            off_reg[ax[0]] <= pfl_pkg::sat32(68'(off_reg[ax[0]]) + p_shift);
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            pfl_pkg::OP_LOAD: in_reg <= in_data;
            pfl_pkg::OP_SQX: p_reg <= prod;
            pfl_pkg::OP_SQZ: begin
                rad_reg <= p_reg[63:0];
                p_reg   <= prod;
            end
            pfl_pkg::OP_ADDSQ: begin
                p_reg   <= $signed({3'b0, rad_reg + p_reg[63:0]});
                r_reg   <= 64'd0;
                bit_reg <= 64'h4000_0000_0000_0000;
            end
            pfl_pkg::OP_SQRT: begin
                if (p_reg[63:0] >= sq_try) begin
                    p_reg <= $signed({3'b0, p_reg[63:0] - sq_try});
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            pfl_pkg::OP_FRACM: p_reg <= prod;
            pfl_pkg::OP_FRACS: begin
                if (p_reg[47:16] > 32'(pfl_pkg::OneQ16)) begin
                    frac_reg <= pfl_pkg::OneQ16;
                end else begin
                    frac_reg <= p_reg[32:16];
                end
            end
            pfl_pkg::OP_NUM: begin
                p_reg <= prod;
                d_reg <= {r_reg[31:0], 16'b0};
                q_reg <= 17'd0;
            end
            pfl_pkg::OP_DIV: begin
                if (p_reg[47:0] >= d_reg) begin
                    p_reg[47:0] <= p_reg[47:0] - d_reg;
                    q_reg       <= {q_reg[15:0], 1'b1};
                end else begin
                    q_reg <= {q_reg[15:0], 1'b0};
                end
                d_reg <= d_reg >> 1;
            end
            pfl_pkg::OP_DIRST: begin
                if (r_reg[31:0] == 32'd0) begin
                    dir_reg[ax[0]] <= 18'sd0;
                end else if (neg_sel) begin
                    dir_reg[ax[0]] <= -$signed({1'b0, q_reg});
                end else begin
                    dir_reg[ax[0]] <= $signed({1'b0, q_reg});
                end
            end
            pfl_pkg::OP_TM: p_reg <= prod;
            pfl_pkg::OP_TS: t_reg <= p_reg[32:16];
            pfl_pkg::OP_OFFM: p_reg <= prod;
            pfl_pkg::OP_VELM: p_reg <= prod;
            pfl_pkg::OP_VELU: vel_reg[ax] <= pfl_pkg::sat32(p_shift + 68'(tv_s[ax]));
            pfl_pkg::OP_POSM: p_reg <= prod;
            pfl_pkg::OP_POSU: pos_reg[ax] <= pfl_pkg::sat32(68'(cur_s[ax]) + p_shift);
            pfl_pkg::OP_OUT: begin
                out_reg.new_pos_x <= pos_reg[0];
                out_reg.new_pos_y <= pos_reg[1];
                out_reg.new_pos_z <= pos_reg[2];
                out_reg.new_vel_x <= vel_reg[0];
                out_reg.new_vel_y <= vel_reg[1];
                out_reg.new_vel_z <= vel_reg[2];
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/proportional_follow_with_lead.sv =====
// one item in flight at a time
// the time per item is set by the 32-step square root, two 17-step
// divisions and the single shared multiplier of the datapath
// the result sits in an output register, so a new item is taken while it waits
// reset: synchronous active-low aresetn clears the sequencer, the result valid flag,
// the lead offsets and the configuration registers to their defaults
module proportional_follow_with_lead (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pfl_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pfl_pkg::out_item_t                  m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pfl_pkg::AddrWidth-1:0]       paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    pfl_pkg::cfg_t     cfg_reg;
    pfl_pkg::cmd_t     cmd;
    pfl_pkg::reg_idx_t reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = pfl_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.position_gain     <= pfl_pkg::GainReset;
            cfg_reg.lead_rate         <= pfl_pkg::RateReset;
            cfg_reg.inverse_max_speed <= pfl_pkg::InvMaxSpeedReset;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                pfl_pkg::REG_GAIN:          cfg_reg.position_gain <= pwdata[23:0];
                pfl_pkg::REG_RATE:          cfg_reg.lead_rate <= pwdata[16:0];
                pfl_pkg::REG_INV_MAX_SPEED: cfg_reg.inverse_max_speed <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pfl_pkg::REG_GAIN:          prdata = {8'b0, cfg_reg.position_gain};
            pfl_pkg::REG_RATE:          prdata = {15'b0, cfg_reg.lead_rate};
            pfl_pkg::REG_INV_MAX_SPEED: prdata = {16'b0, cfg_reg.inverse_max_speed};
            default:                    prdata = 32'd0;
        endcase
    end

    pfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    pfl_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .in_data  (s_data),
        .out_data (m_data)
    );

endmodule
